// ----- hw/rtl/hrbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hrbm_pkg;

	localparam int SLOT_MAX = 6;
	localparam int KEY_W    = 8;
	localparam int MASK_W   = 13;

	typedef logic [KEY_W-1:0]                key_t;
	typedef logic [SLOT_MAX-1:0][KEY_W-1:0]  keys_t;
	typedef logic [MASK_W-1:0]               mask_t;

	// Mapped key codes
	localparam key_t KEY_EMPTY   = 8'h00;
	localparam key_t KEY_UP      = 8'h52;
	localparam key_t KEY_DOWN    = 8'h51;
	localparam key_t KEY_LEFT    = 8'h50;
	localparam key_t KEY_RIGHT   = 8'h4F;
	localparam key_t KEY_A       = 8'h1B;
	localparam key_t KEY_B       = 8'h1D;
	localparam key_t KEY_X       = 8'h16;
	localparam key_t KEY_Y       = 8'h04;
	localparam key_t KEY_L       = 8'h14;
	localparam key_t KEY_R       = 8'h1A;
	localparam key_t KEY_START   = 8'h28;
	localparam key_t KEY_START2  = 8'h58;
	localparam key_t KEY_SELECT  = 8'h2C;
	localparam key_t KEY_ESCAPE  = 8'h29;

	// Button bit positions
	localparam int BTN_UP     = 0;
	localparam int BTN_DOWN   = 1;
	localparam int BTN_LEFT   = 2;
	localparam int BTN_RIGHT  = 3;
	localparam int BTN_A      = 4;
	localparam int BTN_B      = 5;
	localparam int BTN_X      = 6;
	localparam int BTN_Y      = 7;
	localparam int BTN_L      = 8;
	localparam int BTN_R      = 9;
	localparam int BTN_START  = 10;
	localparam int BTN_SELECT = 11;
	localparam int BTN_ESCAPE = 12;

	// Decode one key code into its button bit, zero for unmapped codes
	function automatic mask_t code_to_bit(input key_t code);
		mask_t m;
		m = '0;
		unique case (code)
			KEY_UP:                m[BTN_UP]     = 1'b1;
			KEY_DOWN:              m[BTN_DOWN]   = 1'b1;
			KEY_LEFT:              m[BTN_LEFT]   = 1'b1;
			KEY_RIGHT:             m[BTN_RIGHT]  = 1'b1;
			KEY_A:                 m[BTN_A]      = 1'b1;
			KEY_B:                 m[BTN_B]      = 1'b1;
			KEY_X:                 m[BTN_X]      = 1'b1;
			KEY_Y:                 m[BTN_Y]      = 1'b1;
			KEY_L:                 m[BTN_L]      = 1'b1;
			KEY_R:                 m[BTN_R]      = 1'b1;
			KEY_START, KEY_START2: m[BTN_START]  = 1'b1;
			KEY_SELECT:            m[BTN_SELECT] = 1'b1;
			KEY_ESCAPE:            m[BTN_ESCAPE] = 1'b1;
			default:               m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hrbm_diff.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrbm_diff #(
	parameter int KEY_SLOTS = 6
) (
	input  var hrbm_pkg::keys_t cur_keys,
	input  var hrbm_pkg::keys_t prev_keys,
	input  var hrbm_pkg::mask_t held,
	output var hrbm_pkg::mask_t next_held
);
	import hrbm_pkg::*;

	mask_t set_mask;
	mask_t clr_mask;

	// Compare every live slot of one report against the other report
	always_comb begin
		logic in_prev;
		logic in_cur;
		set_mask = '0;
		clr_mask = '0;
		for (int i = 0; i < SLOT_MAX; i++) begin
			in_prev = 1'b0;
			in_cur  = 1'b0;
			for (int j = 0; j < SLOT_MAX; j++) begin
				if (j < KEY_SLOTS) begin
					if (prev_keys[j] == cur_keys[i]) in_prev = 1'b1;
					if (cur_keys[j] == prev_keys[i]) in_cur  = 1'b1;
				end
			end
			if (i < KEY_SLOTS) begin
				if (cur_keys[i] != KEY_EMPTY && !in_prev)
					set_mask = set_mask | code_to_bit(cur_keys[i]);
				if (prev_keys[i] != KEY_EMPTY && !in_cur)
					clr_mask = clr_mask | code_to_bit(prev_keys[i]);
			end
		end
	end

	// Presses first, then releases win
	assign next_held = (held | set_mask) & ~clr_mask;

endmodule

`default_nettype wire

// ----- hw/rtl/hid_report_to_button_mask_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Keyboard report diff to button mask.
// An accepted report goes to the input register, then its mask to the output register.
// Throughput: one report per cycle unless mask_stall holds the output; a full 6x6 key
// comparator between input and output registers updates held state in the same cycle.
// Reset: arst_n clears the stored report to empty slots, the held mask to zero, and
// both valid flags.

module hid_report_to_button_mask_top #(
	parameter int KEY_SLOTS = 6
) (
	input  var logic             clk,
	input  var logic             arst_n,
	input  var logic             key_valid,
	output var logic             key_stall,
	input  var hrbm_pkg::key_t   key_slot_0,
	input  var hrbm_pkg::key_t   key_slot_1,
	input  var hrbm_pkg::key_t   key_slot_2,
	input  var hrbm_pkg::key_t   key_slot_3,
	input  var hrbm_pkg::key_t   key_slot_4,
	input  var hrbm_pkg::key_t   key_slot_5,
	output var logic             mask_valid,
	input  var logic             mask_stall,
	output var hrbm_pkg::mask_t  button_mask
);
	import hrbm_pkg::*;

	logic  valid_s1;
	keys_t keys_s1;
	keys_t prev_keys_q;
	mask_t held_q;
	mask_t next_held;
	logic  mask_valid_q;
	mask_t button_mask_q;
	logic  advance;
	keys_t store_keys;

	// Move the staged word on when the output register is free or being taken
	assign advance   = valid_s1 && (!mask_valid_q || !mask_stall);
	assign key_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!key_stall) begin
			valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && !key_stall) begin
			keys_s1 <= {key_slot_5, key_slot_4, key_slot_3,
				key_slot_2, key_slot_1, key_slot_0};
		end
	end

	hrbm_diff #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_diff (
		.cur_keys (keys_s1),
		.prev_keys(prev_keys_q),
		.held     (held_q),
		.next_held(next_held)
	);

	// Drop slots past the configured count before storing
	always_comb begin
		for (int i = 0; i < SLOT_MAX; i++) begin
			store_keys[i] = (i < KEY_SLOTS) ? keys_s1[i] : KEY_EMPTY;
		end
	end

	// Update report history and held mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
			held_q      <= '0;
		end else if (advance) begin
			prev_keys_q <= store_keys;
			held_q      <= next_held;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_valid_q <= 1'b0;
		end else if (advance) begin
			mask_valid_q <= 1'b1;
		end else if (!mask_stall) begin
			mask_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			button_mask_q <= next_held;
		end
	end

	assign mask_valid  = mask_valid_q;
	assign button_mask = button_mask_q;

endmodule

`default_nettype wire

// ----- sim/hid_report_to_button_mask_top_tb.sv -----
`timescale 1ns / 1ps

module hid_report_to_button_mask_top_tb;
	import hrbm_pkg::*;

	localparam int SLOT_COUNT  = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 50;

	logic  clk;
	logic  arst_n;
	logic  key_valid;
	logic  key_stall;
	key_t  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5;
	logic  mask_valid;
	logic  mask_stall;
	mask_t button_mask;

	// Model state: last stored report and held buttons
	keys_t prev_report;
	mask_t held_mask;
	mask_t masks_due[$];

	keys_t last_sent;
	bit    idle_en;
	int    hold_left;
	int    errors;
	int    cycles;

	hid_report_to_button_mask_top #(
		.KEY_SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.key_valid(key_valid),
		.key_stall(key_stall),
		.key_slot_0(key_slot_0),
		.key_slot_1(key_slot_1),
		.key_slot_2(key_slot_2),
		.key_slot_3(key_slot_3),
		.key_slot_4(key_slot_4),
		.key_slot_5(key_slot_5),
		.mask_valid(mask_valid),
		.mask_stall(mask_stall),
		.button_mask(button_mask)
	);

	// Generate a 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Map a key code to its button, zero when unmapped
	function automatic mask_t button_of(input key_t code);
		case (code)
			KEY_UP:                return mask_t'(1) << BTN_UP;
			KEY_DOWN:              return mask_t'(1) << BTN_DOWN;
			KEY_LEFT:              return mask_t'(1) << BTN_LEFT;
			KEY_RIGHT:             return mask_t'(1) << BTN_RIGHT;
			KEY_A:                 return mask_t'(1) << BTN_A;
			KEY_B:                 return mask_t'(1) << BTN_B;
			KEY_X:                 return mask_t'(1) << BTN_X;
			KEY_Y:                 return mask_t'(1) << BTN_Y;
			KEY_L:                 return mask_t'(1) << BTN_L;
			KEY_R:                 return mask_t'(1) << BTN_R;
			KEY_START, KEY_START2: return mask_t'(1) << BTN_START;
			KEY_SELECT:            return mask_t'(1) << BTN_SELECT;
			KEY_ESCAPE:            return mask_t'(1) << BTN_ESCAPE;
			default:               return '0;
		endcase
	endfunction

	// Diff the report against the stored one, update held buttons, queue the mask
	task automatic predict_report(input keys_t cur);
		mask_t pressed;
		mask_t released;
		bit    seen;
		pressed  = '0;
		released = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (cur[i] != KEY_EMPTY) begin
				seen = 1'b0;
				for (int j = 0; j < SLOT_COUNT; j++)
					if (prev_report[j] == cur[i]) seen = 1'b1;
				if (!seen) pressed |= button_of(cur[i]);
			end
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (prev_report[i] != KEY_EMPTY) begin
				seen = 1'b0;
				for (int j = 0; j < SLOT_COUNT; j++)
					if (cur[j] == prev_report[i]) seen = 1'b1;
				if (!seen) released |= button_of(prev_report[i]);
			end
		end
		// Release wins over press on a shared button
		held_mask = (held_mask | pressed) & ~released;
		for (int i = 0; i < SLOT_MAX; i++)
			prev_report[i] = (i < SLOT_COUNT) ? cur[i] : KEY_EMPTY;
		masks_due.push_back(held_mask);
	endtask

	task automatic report_mismatch(input string what, input mask_t got, input mask_t want);
		if (errors < PRINT_LIMIT)
			$display("mismatch at %0t: %s, got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic key_t pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 25) return KEY_EMPTY;
		if (r < 85) begin
			case ($urandom_range(13))
				0:       return KEY_UP;
				1:       return KEY_DOWN;
				2:       return KEY_LEFT;
				3:       return KEY_RIGHT;
				4:       return KEY_A;
				5:       return KEY_B;
				6:       return KEY_X;
				7:       return KEY_Y;
				8:       return KEY_L;
				9:       return KEY_R;
				10:      return KEY_START;
				11:      return KEY_START2;
				12:      return KEY_SELECT;
				default: return KEY_ESCAPE;
			endcase
		end
		return key_t'($urandom_range(255));
	endfunction

	function automatic keys_t make_report(input key_t k0, input key_t k1, input key_t k2,
			input key_t k3, input key_t k4, input key_t k5);
		return {k5, k4, k3, k2, k1, k0};
	endfunction

	// Build the next report, mostly a small change from the last one
	function automatic keys_t next_report();
		keys_t k;
		key_t  c;
		int    r;
		k = last_sent;
		r = $urandom_range(99);
		if (r < 50) begin
			repeat ($urandom_range(1, 3)) k[$urandom_range(SLOT_COUNT - 1)] = pick_code();
		end else if (r < 68) begin
			for (int i = 0; i < SLOT_COUNT; i++) k[i] = pick_code();
		end else if (r < 78) begin
			for (int i = 0; i < SLOT_COUNT; i++) k[i] = key_t'($urandom_range(255));
		end else if (r < 88) begin
			// fill with one repeated code
			c = pick_code();
			for (int i = 0; i < SLOT_COUNT; i++)
				k[i] = ($urandom_range(2) != 0) ? c : KEY_EMPTY;
		end else begin
			// swap the two start codes, sometimes add one
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (k[i] == KEY_START) k[i] = KEY_START2;
				else if (k[i] == KEY_START2) k[i] = KEY_START;
			end
			if ($urandom_range(1) != 0)
				k[$urandom_range(SLOT_COUNT - 1)] = ($urandom_range(1) != 0) ? KEY_START
					: KEY_START2;
		end
		return k;
	endfunction

	// Offer one word after an optional gap and hold it until accepted
	task automatic send_report(input keys_t k);
		int gap;
		gap = idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			key_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		key_valid  = 1'b1;
		key_slot_0 = k[0];
		key_slot_1 = k[1];
		key_slot_2 = k[2];
		key_slot_3 = k[3];
		key_slot_4 = k[4];
		key_slot_5 = k[5];
		do @(posedge clk); while (key_stall);
		last_sent = k;
		predict_report(k);
	endtask

	// Drop valid and wait for every queued mask
	task automatic wait_drain();
		@(negedge clk);
		key_valid = 1'b0;
		while (masks_due.size() != 0) @(posedge clk);
	endtask

	// Drive the receiver stall: forced holds first, then random runs
	initial begin
		int run;
		bit stalling;
		run        = 0;
		stalling   = 1'b0;
		mask_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				mask_stall = 1'b1;
				hold_left--;
			end else if (!idle_en) begin
				mask_stall = 1'b0;
			end else begin
				if (run == 0) begin
					stalling = ($urandom_range(99) < 35);
					run      = stalling ? pick_gap() + 1 : $urandom_range(1, 6);
				end
				run--;
				mask_stall = stalling;
			end
		end
	end

	// Check each accepted mask against the oldest prediction
	always @(posedge clk) begin
		mask_t want;
		if (arst_n && mask_valid && !mask_stall) begin
			if (masks_due.size() == 0) begin
				report_mismatch("mask with no report pending", button_mask, '0);
			end else begin
				want = masks_due.pop_front();
				if (button_mask !== want)
					report_mismatch("button_mask", button_mask, want);
			end
		end
	end

	// Mapped codes, unmapped extremes, repeats, reordering and the shared start button
	task automatic test_directed();
		idle_en = 1'b0;
		send_report(make_report(KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		send_report(make_report(KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_A, KEY_B));
		send_report(make_report(KEY_B, KEY_A, KEY_RIGHT, KEY_LEFT, KEY_DOWN, KEY_UP));
		send_report(make_report(KEY_X, KEY_Y, KEY_L, KEY_R, KEY_START, KEY_SELECT));
		send_report(make_report(KEY_ESCAPE, KEY_START2, 8'hFF, 8'h01, 8'h80, 8'h7F));
		send_report(make_report(KEY_START2, KEY_START2, KEY_ESCAPE, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		send_report(make_report(KEY_START, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		send_report(make_report(KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		send_report(make_report(KEY_START2, KEY_START2, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		send_report(make_report(KEY_START2, KEY_START, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		send_report(make_report(KEY_START, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_report(make_report(8'h55, 8'hAA, KEY_UP, KEY_UP, 8'h01, KEY_SELECT));
		send_report(make_report(KEY_SELECT, 8'h55, KEY_UP, 8'hAA, KEY_EMPTY, KEY_EMPTY));
		send_report(make_report(KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY,
			KEY_EMPTY));
		wait_drain();
	endtask

	// Random reports with idling on both sides
	task automatic test_random_traffic(input int count);
		idle_en = 1'b1;
		repeat (count) send_report(next_report());
		wait_drain();
	endtask

	// Back-to-back reports with the receiver always ready
	task automatic test_full_rate(input int count);
		idle_en = 1'b0;
		repeat (count) send_report(next_report());
		wait_drain();
		idle_en = 1'b1;
	endtask

	// Hold the receiver off while reports keep coming, so the input stalls
	task automatic test_back_pressure(input bit with_gaps);
		idle_en   = with_gaps;
		hold_left = 60;
		repeat (40) send_report(next_report());
		wait_drain();
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n      = 1'b0;
		key_valid   = 1'b0;
		key_slot_0  = KEY_EMPTY;
		key_slot_1  = KEY_EMPTY;
		key_slot_2  = KEY_EMPTY;
		key_slot_3  = KEY_EMPTY;
		key_slot_4  = KEY_EMPTY;
		key_slot_5  = KEY_EMPTY;
		idle_en     = 1'b0;
		hold_left   = 0;
		errors      = 0;
		cycles      = 0;
		held_mask   = '0;
		prev_report = '0;
		last_sent   = '0;

		// Hold reset, then release it on a falling clock edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic(500);
		test_back_pressure(1'b0);
		test_full_rate(250);
		test_random_traffic(500);
		test_back_pressure(1'b1);

		// Let any stray word show up before the verdict
		repeat (20) @(posedge clk);
		if (masks_due.size() != 0)
			report_mismatch("reports left without a mask", '0, masks_due[0]);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- hid_report_to_button_mask_top.f -----
hw/rtl/hrbm_pkg.sv
hw/rtl/hrbm_diff.sv
hw/rtl/hid_report_to_button_mask_top.sv
sim/hid_report_to_button_mask_top_tb.sv
